// ----- rtl/bpsd_pkg.sv -----
// ----------------------------------------------------------------------------
// bpsd_pkg
// Shared types and constants of the BMP pixel stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bpsd_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CNT_W      = ($clog2(MAX_DIM + 1) > 12) ? $clog2(MAX_DIM + 1) : 12;

  localparam logic [31:0] HDR_BYTES = 32'd54;
  localparam logic [15:0] BMP_SIG   = 16'h4D42;
  localparam logic [15:0] DEPTH_24  = 16'd24;
  localparam logic [15:0] DEPTH_32  = 16'd32;
  localparam logic [31:0] COMP_RGB  = 32'd0;
  localparam logic [31:0] COMP_BITF = 32'd3;
  localparam logic [7:0]  ALPHA_OPQ = 8'd255;

  localparam int QDEPTH = 2;
  localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_HDR_OK  = 2'd1,
    KIND_HDR_ERR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SIG    = 3'd1,
    ST_COMP   = 3'd2,
    ST_DEPTH  = 3'd3,
    ST_SIZE   = 3'd4,
    ST_OFFSET = 3'd5
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [11:0] col;
    logic [11:0] row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [12:0] img_width;
    logic [12:0] img_height;
    status_e     status;
    logic        last;
    logic        bottom_up;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/bpsd_in_if.sv -----
// ----------------------------------------------------------------------------
// bpsd_in_if
// Byte request channel into the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

`default_nettype wire

// ----- rtl/bpsd_out_if.sv -----
// ----------------------------------------------------------------------------
// bpsd_out_if
// Result request channel out of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] col;
  logic [11:0] row;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [12:0] img_width;
  logic [12:0] img_height;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, output kind, output col, output row, output red,
                  output green, output blue, output alpha, output img_width,
                  output img_height, output status, output last, input ready);
  modport sink   (input valid, input kind, input col, input row, input red,
                  input green, input blue, input alpha, input img_width,
                  input img_height, input status, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/bpsd_fifo.sv -----
// ----------------------------------------------------------------------------
// bpsd_fifo
// Short request queue between the parser front and the output back.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsd_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  input  wire bpsd_pkg::entry_t push_data_i,
  output logic                  push_ready_o,
  output logic                  pop_valid_o,
  output bpsd_pkg::entry_t      pop_data_o,
  input  wire logic             pop_ready_i
);

  bpsd_pkg::entry_t                   mem_q [bpsd_pkg::QDEPTH];
  logic [bpsd_pkg::PTR_W-1:0]         wr_ptr_q, wr_ptr_d;
  logic [bpsd_pkg::PTR_W-1:0]         rd_ptr_q, rd_ptr_d;
  logic [bpsd_pkg::QCNT_W-1:0]        cnt_q, cnt_d;
  logic                               do_push, do_pop;

  assign push_ready_o = (cnt_q != bpsd_pkg::QCNT_W'(bpsd_pkg::QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == bpsd_pkg::PTR_W'(bpsd_pkg::QDEPTH - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == bpsd_pkg::PTR_W'(bpsd_pkg::QDEPTH - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= bpsd_pkg::QCNT_W'(bpsd_pkg::QDEPTH))
    else $error("queue count above depth");
`endif

endmodule

`default_nettype wire

// ----- rtl/bpsd_front.sv -----
// ----------------------------------------------------------------------------
// bpsd_front
// Byte parser: header capture and checks, offset skip, pad drop, pixel build.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsd_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  bpsd_in_if.sink          in_i,
  output logic             push_valid_o,
  output bpsd_pkg::entry_t push_data_o,
  input  wire logic        push_ready_i
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_IDLE
  } phase_e;

  localparam int CW = bpsd_pkg::CNT_W;

  phase_e            phase_q, phase_d;
  logic [31:0]       pos_q, pos_d;
  logic [15:0]       sig_q, sig_d;
  logic [31:0]       offs_q, offs_d;
  logic [31:0]       width_q, width_d;
  logic [31:0]       height_q, height_d;
  logic [15:0]       depth_q, depth_d;
  logic [31:0]       comp_q, comp_d;
  logic              bu_q, bu_d;
  logic [CW-1:0]     col_q, col_d;
  logic [CW-1:0]     row_q, row_d;
  logic [1:0]        bip_q, bip_d;
  logic [1:0]        pad_q, pad_d;
  logic [7:0]        blue_q, blue_d;
  logic [7:0]        green_q, green_d;
  logic [7:0]        red_q, red_d;

  logic              accept;
  logic [7:0]        b;
  logic [1:0]        lane;
  logic              neg;
  logic [31:0]       absh;
  bpsd_pkg::status_e st;
  logic              do_pix;
  logic [7:0]        alpha_v;
  logic              is24;
  logic [CW-1:0]     col_n;
  logic [CW-1:0]     row_n;
  bpsd_pkg::entry_t  ent;
  logic              push;

  assign in_i.ready   = push_ready_i;
  assign accept       = in_i.valid && push_ready_i;
  assign b            = in_i.data_byte;
  assign push_valid_o = push;
  assign push_data_o  = ent;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    sig_d    = sig_q;
    offs_d   = offs_q;
    width_d  = width_q;
    height_d = height_q;
    depth_d  = depth_q;
    comp_d   = comp_q;
    bu_d     = bu_q;
    col_d    = col_q;
    row_d    = row_q;
    bip_d    = bip_q;
    pad_d    = pad_q;
    blue_d   = blue_q;
    green_d  = green_q;
    red_d    = red_q;
    ent      = '0;
    push     = 1'b0;
    do_pix   = 1'b0;
    alpha_v  = bpsd_pkg::ALPHA_OPQ;
    neg      = 1'b0;
    absh     = '0;
    st       = bpsd_pkg::ST_OK;
    lane     = '0;
    is24     = 1'b0;
    col_n    = '0;
    row_n    = '0;
    if (accept) begin
      if (in_i.frame_start) begin
        phase_d  = PH_HEADER;
        pos_d    = '0;
        sig_d    = '0;
        offs_d   = '0;
        width_d  = '0;
        height_d = '0;
        depth_d  = '0;
        comp_d   = '0;
        bu_d     = 1'b1;
        col_d    = '0;
        row_d    = '0;
        bip_d    = '0;
        pad_d    = '0;
        blue_d   = '0;
        green_d  = '0;
        red_d    = '0;
      end
      is24 = (depth_d == bpsd_pkg::DEPTH_24);
      unique case (phase_d)
        PH_HEADER: begin
          lane = pos_d[1:0] - 2'd2;
          if (pos_d < 32'd2) begin
            sig_d[{pos_d[0], 3'b000} +: 8] = b;
          end else if (pos_d >= 32'd10 && pos_d < 32'd14) begin
            offs_d[{lane, 3'b000} +: 8] = b;
          end else if (pos_d >= 32'd18 && pos_d < 32'd22) begin
            width_d[{lane, 3'b000} +: 8] = b;
          end else if (pos_d >= 32'd22 && pos_d < 32'd26) begin
            height_d[{lane, 3'b000} +: 8] = b;
          end else if (pos_d >= 32'd28 && pos_d < 32'd30) begin
            depth_d[{pos_d[0], 3'b000} +: 8] = b;
          end else if (pos_d >= 32'd30 && pos_d < 32'd34) begin
            comp_d[{lane, 3'b000} +: 8] = b;
          end
          pos_d = pos_d + 32'd1;
          if (pos_d == bpsd_pkg::HDR_BYTES) begin
            neg  = height_d[31];
            absh = neg ? (~height_d + 32'd1) : height_d;
            bu_d = !neg;
            priority if (sig_d != bpsd_pkg::BMP_SIG) begin
              st = bpsd_pkg::ST_SIG;
            end else if (comp_d != bpsd_pkg::COMP_RGB && comp_d != bpsd_pkg::COMP_BITF) begin
              st = bpsd_pkg::ST_COMP;
            end else if (depth_d != bpsd_pkg::DEPTH_24 && depth_d != bpsd_pkg::DEPTH_32) begin
              st = bpsd_pkg::ST_DEPTH;
            end else if (width_d[31] || width_d > 32'(bpsd_pkg::MAX_WIDTH) ||
                         absh > 32'(bpsd_pkg::MAX_HEIGHT)) begin
              st = bpsd_pkg::ST_SIZE;
            end else if (offs_d < bpsd_pkg::HDR_BYTES) begin
              st = bpsd_pkg::ST_OFFSET;
            end else begin
              st = bpsd_pkg::ST_OK;
            end
            push       = 1'b1;
            ent.status = st;
            if (st != bpsd_pkg::ST_OK) begin
              ent.kind = bpsd_pkg::KIND_HDR_ERR;
              ent.last = 1'b1;
              phase_d  = PH_IDLE;
            end else begin
              height_d       = absh;
              ent.kind       = bpsd_pkg::KIND_HDR_OK;
              ent.img_width  = width_d[12:0];
              ent.img_height = absh[12:0];
              ent.bottom_up  = !neg;
              if (width_d == '0 || absh == '0) begin
                ent.last = 1'b1;
                phase_d  = PH_IDLE;
              end else if (offs_d == bpsd_pkg::HDR_BYTES) begin
                phase_d = PH_PIXELS;
              end else begin
                phase_d = PH_SKIP;
              end
            end
          end
        end
        PH_SKIP: begin
          pos_d = pos_d + 32'd1;
          if (pos_d == offs_d) begin
            phase_d = PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          if (pad_d != 2'd0) begin
            pad_d = pad_d - 2'd1;
          end else begin
            unique case (bip_d)
              2'd0: begin
                blue_d = b;
                bip_d  = 2'd1;
              end
              2'd1: begin
                green_d = b;
                bip_d   = 2'd2;
              end
              2'd2: begin
                red_d = b;
                if (is24) begin
                  bip_d  = 2'd0;
                  do_pix = 1'b1;
                end else begin
                  bip_d = 2'd3;
                end
              end
              default: begin
                bip_d   = 2'd0;
                alpha_v = b;
                do_pix  = 1'b1;
              end
            endcase
          end
          if (do_pix) begin
            push      = 1'b1;
            ent.kind  = bpsd_pkg::KIND_PIXEL;
            ent.col   = col_d[11:0];
            ent.row   = row_d[11:0];
            ent.red   = red_d;
            ent.green = green_d;
            ent.blue  = blue_d;
            ent.alpha = alpha_v;
            col_n     = col_d + 1'b1;
            col_d     = col_n;
            if (col_n == width_d[CW-1:0]) begin
              col_d = '0;
              row_n = row_d + 1'b1;
              row_d = row_n;
              if (is24) begin
                pad_d = width_d[1:0];
              end
              if (row_n == height_d[CW-1:0]) begin
                ent.last = 1'b1;
                phase_d  = PH_IDLE;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      pos_q    <= '0;
      sig_q    <= '0;
      offs_q   <= '0;
      width_q  <= '0;
      height_q <= '0;
      depth_q  <= '0;
      comp_q   <= '0;
      bu_q     <= 1'b1;
      col_q    <= '0;
      row_q    <= '0;
      bip_q    <= '0;
      pad_q    <= '0;
      blue_q   <= '0;
      green_q  <= '0;
      red_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      sig_q    <= sig_d;
      offs_q   <= offs_d;
      width_q  <= width_d;
      height_q <= height_d;
      depth_q  <= depth_d;
      comp_q   <= comp_d;
      bu_q     <= bu_d;
      col_q    <= col_d;
      row_q    <= row_d;
      bip_q    <= bip_d;
      pad_q    <= pad_d;
      blue_q   <= blue_d;
      green_q  <= green_d;
      red_q    <= red_d;
    end
  end

`ifndef SYNTHESIS
  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o |-> (in_i.valid && in_i.ready))
    else $error("queue push without byte accept");
  a_pad_24_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PIXELS && pad_q != 2'd0) |-> (depth_q == bpsd_pkg::DEPTH_24))
    else $error("row pad pending outside 24-bit data");
`endif

endmodule

`default_nettype wire

// ----- rtl/bpsd_back.sv -----
// ----------------------------------------------------------------------------
// bpsd_back
// Result stage: row flip and registered output toward the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsd_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             pop_valid_i,
  input  wire bpsd_pkg::entry_t pop_data_i,
  output logic                  pop_ready_o,
  bpsd_out_if.source            out_o
);

  logic             ov_q, ov_d;
  bpsd_pkg::entry_t res_q, res_d;
  logic             bu_q, bu_d;
  logic [11:0]      hgt_q, hgt_d;
  logic             do_pop;

  assign pop_ready_o = !ov_q || out_o.ready;
  assign do_pop      = pop_valid_i && pop_ready_o;

  always_comb begin
    ov_d  = ov_q;
    res_d = res_q;
    bu_d  = bu_q;
    hgt_d = hgt_q;
    if (do_pop) begin
      ov_d  = 1'b1;
      res_d = pop_data_i;
      if (pop_data_i.kind == bpsd_pkg::KIND_HDR_OK) begin
        bu_d  = pop_data_i.bottom_up;
        hgt_d = pop_data_i.img_height[11:0];
      end
      if (pop_data_i.kind == bpsd_pkg::KIND_PIXEL && bu_q) begin
        res_d.row = hgt_q - 12'd1 - pop_data_i.row;
      end
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      bu_q  <= 1'b1;
      hgt_q <= '0;
    end else begin
      ov_q  <= ov_d;
      bu_q  <= bu_d;
      hgt_q <= hgt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid      = ov_q;
  assign out_o.kind       = res_q.kind;
  assign out_o.col        = res_q.col;
  assign out_o.row        = res_q.row;
  assign out_o.red        = res_q.red;
  assign out_o.green      = res_q.green;
  assign out_o.blue       = res_q.blue;
  assign out_o.alpha      = res_q.alpha;
  assign out_o.img_width  = res_q.img_width;
  assign out_o.img_height = res_q.img_height;
  assign out_o.status     = res_q.status;
  assign out_o.last       = res_q.last;

`ifndef SYNTHESIS
  a_pixel_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && res_q.kind == bpsd_pkg::KIND_PIXEL) |-> (res_q.status == bpsd_pkg::ST_OK))
    else $error("pixel result with nonzero status");
`endif

endmodule

`default_nettype wire

// ----- rtl/bmp_pixel_stream_decoder_top.sv -----
// ----------------------------------------------------------------------------
// bmp_pixel_stream_decoder_top
// Streaming decoder for 24/32-bit BMP files, one file byte per request.
//
// in_i  : one byte per request; frame_start restarts parsing at that byte.
// out_o : one header result after the 54-byte header (size or error status), then one
//         RGBA pixel per 3 or 4 data bytes with top-down row and column;
//         last marks the final result of a file. Row pad and bytes before
//         the data offset produce nothing; bytes after last are ignored.
// Throughput: one byte per cycle, set by the byte parser, while the queue has room.
// Path: a result is registered in the queue, then in the output register
//         (parser -> two-entry queue -> output register) before it is on out_o.
// Stall: out_o holds its result while ready is low; the queue absorbs two
//         more results, then in_i.ready drops until the sink drains.
// Reset: parser waits for byte 0 of a new file, queue empty, no output.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_pixel_stream_decoder_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bpsd_in_if.sink    in_i,
  bpsd_out_if.source out_o
);

  logic             push_valid, push_ready;
  bpsd_pkg::entry_t push_data;
  logic             pop_valid, pop_ready;
  bpsd_pkg::entry_t pop_data;

  bpsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  bpsd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  bpsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
